@@ src/atdc_pkg.sv @@
// Package for the averaged temperature duty controller.
// Holds field widths, arithmetic constants and the controller/datapath link types.
// No dependencies.
package atdc_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned GOAL_W     = 8;
  localparam int unsigned DUTY_CMP_W = 10;
  localparam int unsigned TEMP_W     = 9;

  // Default averaging window
  localparam int unsigned WINDOW_DEF = 10;

  // Register reset value
  localparam logic [GOAL_W-1:0] GOAL_RESET = 8'd40;

  // Temperature scaling: temp = (avg * 330) >> 10
  localparam int unsigned SCALE_W     = 19;
  localparam logic [SCALE_W-1:0] SCALE_MUL = 19'd330;
  localparam int unsigned SCALE_SHIFT = 10;

  // Proportional gain selection
  localparam logic [GOAL_W-1:0] GAIN_SEL_LIM = 8'd60;
  localparam logic signed [5:0] GAIN_HIGH    = 6'sd20;
  localparam logic signed [5:0] GAIN_LOW     = 6'sd3;

  // Corrected value width
  localparam int unsigned CORR_W = 14;

  // Duty map breakpoints
  localparam logic signed [CORR_W-1:0] BRK_HOT  = 14'sd76;
  localparam logic signed [CORR_W-1:0] BRK_MID  = 14'sd31;
  localparam logic signed [CORR_W-1:0] BRK_COLD = 14'sd20;

  // Upper line: 63 - floor(84c/100) = 63 - ((c * 27531) >> 15)
  localparam int unsigned LINE1_W     = 21;
  localparam logic [LINE1_W-1:0] LINE1_RECIP = 21'd27531;
  localparam int unsigned LINE1_SHIFT = 15;
  localparam logic [7:0] LINE1_OFS    = 8'd63;

  // Lower line: 187 - floor(49c/10) = 187 - ((c * 321146) >> 16)
  localparam int unsigned LINE2_W     = 26;
  localparam logic [LINE2_W-1:0] LINE2_RECIP = 26'd321146;
  localparam int unsigned LINE2_SHIFT = 16;
  localparam logic [7:0] LINE2_OFS    = 8'd187;

  // Duty levels
  localparam logic [7:0] DUTY_HOT = 8'd10;
  localparam logic [7:0] DUTY_MAX = 8'd100;
  localparam logic [DUTY_CMP_W-1:0] DUTY_SCALE = 10'd10;

  // Limits of the result fields
  localparam logic [DUTY_CMP_W-1:0] DUTY_CMP_MAX = 10'd1000;
  localparam logic [TEMP_W-1:0]     TEMP_MAX     = 9'd329;

  // Commands from controller to datapath
  typedef struct packed {
    logic wr_en;     // store the incoming sample
    logic sum_clr;   // clear accumulator
    logic rd_en;     // read one stored sample
    logic div_step;  // divide the sum by the window length
    logic scale_en;  // convert average to temperature
    logic corr_en;   // apply proportional correction
    logic mul_en;    // form both duty line products
    logic load_out;  // load the result register
  } atdc_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;  // result register free to take a new transaction
  } atdc_sts_t;

endpackage

@@ src/atdc_in_if.sv @@
// Input channel interface: valid/ready handshake carrying one ADC sample.
// Depends on atdc_pkg.
interface atdc_in_if;
  import atdc_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

@@ src/atdc_out_if.sv @@
// Result channel interface: valid/ready handshake carrying compare value and temperature.
// Depends on atdc_pkg.
interface atdc_out_if;
  import atdc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [DUTY_CMP_W-1:0] duty_compare;
  logic [TEMP_W-1:0]     measured_temp;

  modport source (output valid, output duty_compare, output measured_temp, input ready);
  modport sink   (input valid, input duty_compare, input measured_temp, output ready);
endinterface

@@ src/atdc_ctrl.sv @@
// Controller for the averaged temperature duty controller: fill count, sequencing
// of sum, division and map stages. Depends on atdc_pkg.
module atdc_ctrl #(
  parameter int unsigned WINDOW = atdc_pkg::WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  atdc_pkg::atdc_sts_t  sts,
  output atdc_pkg::atdc_cmd_t  cmd,
  output logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] mem_addr
);
  import atdc_pkg::*;

  localparam int unsigned IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FILL_W  = $clog2(WINDOW + 1);
  localparam int unsigned CNT_W   = $clog2(WINDOW + 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SUM   = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_SCALE = 7'b0001000,
    ST_CORR  = 7'b0010000,
    ST_MUL   = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } atdc_state_t;

  atdc_state_t       state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // Next state, counters and commands
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    mem_addr  = cnt_r[IDX_W-1:0];
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        mem_addr = fill_r[IDX_W-1:0];
        if (in_valid) begin
          if (fill_r < FILL_W'(WINDOW)) begin
            cmd.wr_en = 1'b1;
            fill_nxt  = fill_r + 1'b1;
          end else begin
            // window full: drop this sample and start the computation
            fill_nxt    = '0;
            cnt_nxt     = '0;
            cmd.sum_clr = 1'b1;
            state_nxt   = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        // read one entry a cycle; the last read lands in the cycle after it is issued
        cmd.rd_en = (cnt_r < CNT_W'(WINDOW));
        if (cnt_r == CNT_W'(WINDOW)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale_en = 1'b1;
        state_nxt    = ST_CORR;
      end
      ST_CORR: begin
        cmd.corr_en = 1'b1;
        state_nxt   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the result register is free
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ src/atdc_dp.sv @@
// Datapath for the averaged temperature duty controller: sample memory, accumulator
// with reciprocal divide, scaling, correction, duty map and result register. Depends on atdc_pkg.
module atdc_dp #(
  parameter int unsigned WINDOW = atdc_pkg::WINDOW_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  atdc_pkg::atdc_cmd_t                cmd,
  output atdc_pkg::atdc_sts_t                sts,
  input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] mem_addr,
  input  logic [atdc_pkg::SAMPLE_W-1:0]      adc_sample,
  input  logic                               cfg_we,
  input  logic [atdc_pkg::GOAL_W-1:0]        cfg_wdata,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [atdc_pkg::DUTY_CMP_W-1:0]    duty_compare,
  output logic [atdc_pkg::TEMP_W-1:0]        measured_temp
);
  import atdc_pkg::*;

  localparam int unsigned SUM_W     = SAMPLE_W + $clog2(WINDOW + 1);
  // floor(sum / WINDOW) = (sum * ceil(2^DIV_SHIFT / WINDOW)) >> DIV_SHIFT for any sum
  localparam int unsigned DIV_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int unsigned RECIP_W   = SUM_W + 1;
  localparam int unsigned DIVP_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'(((longint'(1) << DIV_SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW));

  // Sample memory
  logic [SAMPLE_W-1:0] store [WINDOW];
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                acc_en_r;

  // Accumulator / divider
  logic [SUM_W-1:0]  sum_r;
  logic [DIVP_W-1:0] div_prod;

  // Arithmetic stages
  logic [GOAL_W-1:0]        goal_r;
  logic [SCALE_W-1:0]       prod_r;
  logic [TEMP_W-1:0]        temp;
  logic signed [10:0]       diff;
  logic signed [5:0]        gain;
  logic signed [16:0]       kd;
  logic signed [CORR_W-1:0] corr_c, corr_r;
  logic [6:0]               c_low;
  logic [LINE1_W-1:0]       m1_r;
  logic [LINE2_W-1:0]       m2_r;
  logic [7:0]               duty, duty_cl;

  // Result register
  logic                  out_valid_r;
  logic [DUTY_CMP_W-1:0] duty_cmp_r;
  logic [TEMP_W-1:0]     temp_out_r;

  // Write and read the sample memory
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      store[mem_addr] <= adc_sample;
    end
    if (cmd.rd_en) begin
      rd_data_r <= store[mem_addr];
    end
  end

  // Track which cycles carry read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= cmd.rd_en;
    end
  end

  // Divide by the window length with a reciprocal multiply
  assign div_prod = DIVP_W'(sum_r) * DIVP_W'(DIV_RECIP);

  // Accumulate, then replace the sum by the average
  always_ff @(posedge clk) begin
    if (cmd.sum_clr) begin
      sum_r <= '0;
    end else if (acc_en_r) begin
      sum_r <= sum_r + SUM_W'(rd_data_r);
    end else if (cmd.div_step) begin
      sum_r <= SUM_W'(div_prod >> DIV_SHIFT);
    end
  end

  // Goal register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_r <= GOAL_RESET;
    end else if (cfg_we) begin
      goal_r <= cfg_wdata;
    end
  end

  // Average to degrees
  always_ff @(posedge clk) begin
    if (cmd.scale_en) begin
      prod_r <= SCALE_W'(sum_r[SAMPLE_W-1:0]) * SCALE_MUL;
    end
  end
  assign temp = prod_r[SCALE_W-1:SCALE_SHIFT];

  // Proportional correction
  always_comb begin
    diff   = $signed({3'b000, goal_r}) - $signed({2'b00, temp});
    gain   = (goal_r > GAIN_SEL_LIM) ? GAIN_HIGH : GAIN_LOW;
    kd     = diff * gain;
    corr_c = kd[CORR_W-1:0] + $signed({6'b000000, goal_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.corr_en) begin
      corr_r <= corr_c;
    end
  end

  // Reciprocal products for both fitted lines
  assign c_low = corr_r[6:0];
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      m1_r <= LINE1_W'(c_low) * LINE1_RECIP;
      m2_r <= LINE2_W'(c_low) * LINE2_RECIP;
    end
  end

  // Piecewise duty map and clamp
  always_comb begin
    priority if (corr_r > BRK_HOT) begin
      duty = DUTY_HOT;
    end else if (corr_r > BRK_MID) begin
      duty = LINE1_OFS - 8'(m1_r[LINE1_W-1:LINE1_SHIFT]);
    end else if (corr_r > BRK_COLD) begin
      duty = LINE2_OFS - m2_r[LINE2_SHIFT+7:LINE2_SHIFT];
    end else begin
      duty = DUTY_MAX;
    end
    duty_cl = (duty > DUTY_MAX) ? DUTY_MAX : duty;
  end

  // Result register: load a new transaction, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      duty_cmp_r <= DUTY_CMP_W'(duty_cl) * DUTY_SCALE;
      temp_out_r <= temp;
    end
  end

  assign sts.out_free  = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign duty_compare  = duty_cmp_r;
  assign measured_temp = temp_out_r;

endmodule

@@ src/averaged_temperature_duty_controller.sv @@
// Top level of the averaged temperature duty controller: controller plus datapath.
// Depends on atdc_pkg, atdc_in_if, atdc_out_if, atdc_ctrl and atdc_dp.
//
//   channel  | direction | handshake    | payload
//   in_ch    | in        | valid/ready  | adc_sample[9:0]
//   out_ch   | out       | valid/ready  | duty_compare[9:0], measured_temp[8:0]
//   cfg_*    | in        | cfg_we       | cfg_wdata[7:0] (goal_temp)
//
// A sample that goes into the store leaves input ready for the next sample. The computing
// transaction runs one memory read a cycle for the sum, one reciprocal multiply for the
// average, then scale, correction, map.
// Input is held off during the computation and while a result waits to be loaded;
// a result already in the output register does not block storing samples.
// Synchronous active-low reset clears the fill count, state and goal (to 40).
module averaged_temperature_duty_controller #(
  parameter int unsigned WINDOW = atdc_pkg::WINDOW_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  atdc_in_if.sink                      in_ch,
  atdc_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [atdc_pkg::GOAL_W-1:0]  cfg_wdata
);
  import atdc_pkg::*;

  localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  atdc_cmd_t        cmd;
  atdc_sts_t        sts;
  logic [IDX_W-1:0] mem_addr;

  atdc_ctrl #(
    .WINDOW (WINDOW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd),
    .mem_addr (mem_addr)
  );

  atdc_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .mem_addr      (mem_addr),
    .adc_sample    (in_ch.adc_sample),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .duty_compare  (out_ch.duty_compare),
    .measured_temp (out_ch.measured_temp)
  );

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_ch.valid || out_ch.ready))
    else $error("result register loaded while holding an untaken transaction");

  // Stored samples are read only while input is held off
  a_read_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> !in_ch.ready)
    else $error("sample memory read while input accepted");

  // A sample is written only on an accepted transaction
  a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> (in_ch.valid && in_ch.ready))
    else $error("sample written without an input transaction");

  // A newly loaded result lies within the field ranges
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (out_ch.duty_compare <= DUTY_CMP_MAX &&
                      out_ch.measured_temp <= TEMP_MAX))
    else $error("result field out of range");

endmodule
